// ===== rtl/fnseg_pkg.sv =====
// ----------------------------------------------------------------------------
// fnseg_pkg
// Shared constants, types and helpers for the frame note segmenter.
// ----------------------------------------------------------------------------
package fnseg_pkg;

    localparam int PITCH_COUNT = 128;
    localparam int FRAME_BITS  = 24;

    localparam int PITCH_W = 7;
    localparam int PROB_W  = 16;
    localparam int VEL_W   = 7;
    localparam int FIELD_W = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    localparam logic [PROB_W-1:0] NOTE_THR_RESET  = PROB_W'(19661);
    localparam logic [PROB_W-1:0] ONSET_THR_RESET = PROB_W'(32768);
    localparam logic [VEL_W-1:0]  DEF_VEL_RESET   = VEL_W'(80);

    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOTE_THR  = 2'd0,
        CFG_ONSET_THR = 2'd1,
        CFG_DEF_VEL   = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        OP_PITCH = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic {
        EV_FRAME = 1'b0,
        EV_FLUSH = 1'b1
    } ev_kind_t;

    // Frame summary passed from the front to the back
    typedef struct packed {
        ev_kind_t             kind;
        logic                 onset_hit;
        logic                 start_hit;
        logic [PITCH_W-1:0]   pitch;
        logic [VEL_W-1:0]     velocity;
    } event_t;

    // Clamp a frame count to the width of a result field
    function automatic logic [FIELD_W-1:0] sat_field(input logic [FRAME_BITS-1:0] v);
        logic [FRAME_BITS+FIELD_W-1:0] ext;
        logic [FRAME_BITS+FIELD_W-1:0] lim;
        ext = {{FIELD_W{1'b0}}, v};
        lim = {{FRAME_BITS{1'b0}}, {FIELD_W{1'b1}}};
        if (ext > lim)
            sat_field = {FIELD_W{1'b1}};
        else
            sat_field = ext[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/fnseg_front.sv =====
// ----------------------------------------------------------------------------
// fnseg_front
// Accepts pitch and flush beats, keeps the running argmax and classifies frame ends.
// ----------------------------------------------------------------------------
module fnseg_front
    import fnseg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_op,
    input  logic                 in_last,
    input  logic [PITCH_W-1:0]   in_pitch,
    input  logic [PROB_W-1:0]    in_prob,
    input  logic [VEL_W-1:0]     in_vel,
    input  logic                 in_vel_present,
    input  logic [PROB_W-1:0]    in_onset,
    input  logic                 q_full,
    output logic                 q_push,
    output event_t               q_data
);

    logic [PROB_W-1:0]  note_thr_reg;
    logic [PROB_W-1:0]  onset_thr_reg;
    logic [VEL_W-1:0]   def_vel_reg;

    logic [PROB_W-1:0]  best_prob_reg, best_prob_next;
    logic [PITCH_W-1:0] best_pitch_reg, best_pitch_next;
    logic [VEL_W-1:0]   best_vel_reg, best_vel_next;

    logic               accept;
    logic               take;
    logic [PROB_W-1:0]  cand_prob;
    logic [PITCH_W-1:0] cand_pitch;
    logic [VEL_W-1:0]   cand_vel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_thr_reg  <= NOTE_THR_RESET;
            onset_thr_reg <= ONSET_THR_RESET;
            def_vel_reg   <= DEF_VEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NOTE_THR:  note_thr_reg  <= cfg_data;
                CFG_ONSET_THR: onset_thr_reg <= cfg_data;
                CFG_DEF_VEL:   def_vel_reg   <= cfg_data[VEL_W-1:0];
                default:       ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Strict compare: the earliest pitch keeps a tie
    always_comb
    begin
        take = ({1'b0, in_pitch} < (PITCH_W+1)'(PITCH_COUNT)) && (in_prob > best_prob_reg);
        if (take)
        begin
            cand_prob  = in_prob;
            cand_pitch = in_pitch;
            cand_vel   = in_vel_present ? in_vel : def_vel_reg;
        end
        else
        begin
            cand_prob  = best_prob_reg;
            cand_pitch = best_pitch_reg;
            cand_vel   = best_vel_reg;
        end
    end

    always_comb
    begin
        best_prob_next  = best_prob_reg;
        best_pitch_next = best_pitch_reg;
        best_vel_next   = best_vel_reg;
        q_push          = 1'b0;
        q_data.kind      = EV_FRAME;
        q_data.onset_hit = in_onset > onset_thr_reg;
        q_data.start_hit = cand_prob > note_thr_reg;
        q_data.pitch     = cand_pitch;
        q_data.velocity  = cand_vel;

        if (accept)
        begin
            if (op_t'(in_op) == OP_FLUSH)
            begin
                // drop any partial frame
                q_push          = 1'b1;
                q_data.kind     = EV_FLUSH;
                best_prob_next  = '0;
                best_pitch_next = '0;
                best_vel_next   = '0;
            end
            else if (in_last)
            begin
                q_push          = 1'b1;
                best_prob_next  = '0;
                best_pitch_next = '0;
                best_vel_next   = '0;
            end
            else
            begin
                best_prob_next  = cand_prob;
                best_pitch_next = cand_pitch;
                best_vel_next   = cand_vel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_prob_reg  <= '0;
            best_pitch_reg <= '0;
            best_vel_reg   <= '0;
        end
        else
        begin
            best_prob_reg  <= best_prob_next;
            best_pitch_reg <= best_pitch_next;
            best_vel_reg   <= best_vel_next;
        end
    end

endmodule

// ===== rtl/fnseg_fifo.sv =====
// ----------------------------------------------------------------------------
// fnseg_fifo
// Two-entry queue of frame events between the front and the back.
// ----------------------------------------------------------------------------
module fnseg_fifo
    import fnseg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output event_t pop_data
);

    event_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full     = count_reg == 2'd2;
    assign valid    = count_reg != 2'd0;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/fnseg_back.sv =====
// ----------------------------------------------------------------------------
// fnseg_back
// Tracks the active note, counts frames and issues finished notes.
// ----------------------------------------------------------------------------
module fnseg_back
    import fnseg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  event_t                q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic [FRAME_BITS-1:0] frame_cnt_reg, frame_cnt_next;
    logic                  active_reg, active_next;
    logic [PITCH_W-1:0]    act_pitch_reg, act_pitch_next;
    logic [VEL_W-1:0]      act_vel_reg, act_vel_next;
    logic [FRAME_BITS-1:0] act_start_reg, act_start_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [FRAME_BITS-1:0] len;
    logic [OUT_DATA_W-1:0] note_beat;
    logic                  close;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        len = frame_cnt_reg - act_start_reg;
        if (len == '0)
            len = FRAME_BITS'(1);
        note_beat = {{(OUT_DATA_W-2*FIELD_W-PITCH_W-VEL_W){1'b0}},
                     sat_field(len), sat_field(act_start_reg), act_vel_reg, act_pitch_reg};
    end

    always_comb
    begin
        frame_cnt_next = frame_cnt_reg;
        active_next    = active_reg;
        act_pitch_next = act_pitch_reg;
        act_vel_next   = act_vel_reg;
        act_start_next = act_start_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        close          = 1'b0;

        if (q_pop)
        begin
            unique case (q_data.kind)
                EV_FLUSH:
                begin
                    close          = active_reg;
                    frame_cnt_next = '0;
                    active_next    = 1'b0;
                    act_pitch_next = '0;
                    act_vel_next   = '0;
                    act_start_next = '0;
                end
                EV_FRAME:
                begin
                    if (q_data.onset_hit || !active_reg)
                    begin
                        close       = active_reg;
                        active_next = q_data.start_hit;
                        if (q_data.start_hit)
                        begin
                            act_pitch_next = q_data.pitch;
                            act_vel_next   = q_data.velocity;
                            act_start_next = frame_cnt_reg;
                        end
                    end
                    if (frame_cnt_reg != FRAME_MAX)
                        frame_cnt_next = frame_cnt_reg + FRAME_BITS'(1);
                end
                default: ;
            endcase

            if (close)
            begin
                out_valid_next = 1'b1;
                out_data_next  = note_beat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            active_reg    <= 1'b0;
            act_pitch_reg <= '0;
            act_vel_reg   <= '0;
            act_start_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_cnt_reg <= frame_cnt_next;
            active_reg    <= active_next;
            act_pitch_reg <= act_pitch_next;
            act_vel_reg   <= act_vel_next;
            act_start_reg <= act_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/frame_note_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// frame_note_segmenter_top
// Turns a stream of per-pitch probabilities into finished note beats.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while s_tready is high. The front
// handles each beat and keeps the running argmax; a beat that ends a frame
// or flushes the sequence puts one event into a two-entry queue. The back
// takes one event per cycle while its output register is free or being taken,
// and writes any finished note into that register, which drives m_tvalid.
// Input stalls only when the output is held long enough for the event queue
// to fill: the back holds its waiting note, the queue takes two more events,
// and s_tready then drops until the note is taken.
// ----------------------------------------------------------------------------
module frame_note_segmenter_top
    import fnseg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pitch_index[6:0], probability[22:7], velocity_value[29:23],
    // velocity_present[30], onset_level[46:31], zero pad[47]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // note_pitch[6:0], note_velocity[13:7], start_frame[37:14],
    // length_frames[61:38], zero pad[63:62]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    event_t q_in;
    event_t q_out;

    fnseg_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_op          (s_tuser),
        .in_last        (s_tlast),
        .in_pitch       (s_tdata[6:0]),
        .in_prob        (s_tdata[22:7]),
        .in_vel         (s_tdata[29:23]),
        .in_vel_present (s_tdata[30]),
        .in_onset       (s_tdata[46:31]),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    fnseg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    fnseg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== tb/fnseg_note_checker.sv =====
// ----------------------------------------------------------------------------
// fnseg_note_checker
// Watches the beat, note and register ports of the frame note segmenter,
// predicts every finished note from the accepted beats and compares each
// note beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fnseg_note_checker
    import fnseg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // pitch_index[6:0], probability[22:7], velocity_value[29:23],
    // velocity_present[30], onset_level[46:31], zero pad[47]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // note_pitch[6:0], note_velocity[13:7], start_frame[37:14],
    // length_frames[61:38], zero pad[63:62]
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    notes_owed
);

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   velocity;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
    } note_t;

    note_t owed_notes[$];

    // register copies
    logic [PROB_W-1:0]     note_thr;
    logic [PROB_W-1:0]     onset_thr;
    logic [VEL_W-1:0]      dflt_vel;

    // segmenter state
    logic [FRAME_BITS-1:0] frame_no;
    logic [PROB_W-1:0]     peak_prob;
    logic [PITCH_W-1:0]    peak_pitch;
    logic [VEL_W-1:0]      peak_vel;
    logic                  holding;
    logic [PITCH_W-1:0]    held_pitch;
    logic [VEL_W-1:0]      held_vel;
    logic [FRAME_BITS-1:0] held_start;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("note mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [FIELD_W-1:0] clamp_frames(input logic [FRAME_BITS-1:0] v);
        if (64'(v) > 64'((64'd1 << FIELD_W) - 1))
            return '1;
        return FIELD_W'(v);
    endfunction

    task automatic clear_segmenter();
        frame_no   = '0;
        peak_prob  = '0;
        peak_pitch = '0;
        peak_vel   = '0;
        holding    = 1'b0;
        held_pitch = '0;
        held_vel   = '0;
        held_start = '0;
    endtask

    task automatic close_note();
        logic [FRAME_BITS-1:0] span;
        note_t                 n;
        span = (frame_no >= held_start) ? frame_no - held_start : '0;
        // a saturated counter can give zero length; report one frame
        if (span == '0)
            span = FRAME_BITS'(1);
        n.pitch    = held_pitch;
        n.velocity = held_vel;
        n.start    = clamp_frames(held_start);
        n.length   = clamp_frames(span);
        owed_notes.insert(owed_notes.size(), n);
    endtask

    task automatic segment_beat(input op_t op, input logic [IN_DATA_W-1:0] d,
                                input logic frame_end);
        logic [PITCH_W-1:0] pitch;
        logic [PROB_W-1:0]  prob;
        logic [VEL_W-1:0]   vel;
        logic               vel_ok;
        logic [PROB_W-1:0]  onset;
        pitch  = d[6:0];
        prob   = d[22:7];
        vel    = d[29:23];
        vel_ok = d[30];
        onset  = d[46:31];
        if (op == OP_FLUSH)
        begin
            if (holding)
                close_note();
            clear_segmenter();
        end
        else
        begin
            // strict compare: the earliest pitch keeps a tie
            if (int'(pitch) < PITCH_COUNT && prob > peak_prob)
            begin
                peak_prob  = prob;
                peak_pitch = pitch;
                peak_vel   = vel_ok ? vel : dflt_vel;
            end
            if (frame_end)
            begin
                if (onset > onset_thr || !holding)
                begin
                    if (holding)
                        close_note();
                    if (peak_prob > note_thr)
                    begin
                        holding    = 1'b1;
                        held_pitch = peak_pitch;
                        held_vel   = peak_vel;
                        held_start = frame_no;
                    end
                    else
                        holding = 1'b0;
                end
                peak_prob  = '0;
                peak_pitch = '0;
                peak_vel   = '0;
                if (frame_no != FRAME_MAX)
                    frame_no++;
            end
        end
    endtask

    initial
    begin
        mismatches = 0;
        notes_owed = 0;
        note_thr   = NOTE_THR_RESET;
        onset_thr  = ONSET_THR_RESET;
        dflt_vel   = DEF_VEL_RESET;
        clear_segmenter();
    end

    always @(posedge clk)
    begin
        note_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_notes.size() == 0)
                    report_mismatch("note with none owed", m_tdata, '0);
                else
                begin
                    want = owed_notes.pop_front();
                    if (m_tdata[6:0] !== want.pitch)
                        report_mismatch("note_pitch", m_tdata[6:0], want.pitch);
                    if (m_tdata[13:7] !== want.velocity)
                        report_mismatch("note_velocity", m_tdata[13:7], want.velocity);
                    if (m_tdata[37:14] !== want.start)
                        report_mismatch("start_frame", m_tdata[37:14], want.start);
                    if (m_tdata[61:38] !== want.length)
                        report_mismatch("length_frames", m_tdata[61:38], want.length);
                end
            end
            if (s_tvalid && s_tready)
                segment_beat(op_t'(s_tuser), s_tdata, s_tlast);
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_NOTE_THR:  note_thr  = cfg_data[PROB_W-1:0];
                    CFG_ONSET_THR: onset_thr = cfg_data[PROB_W-1:0];
                    CFG_DEF_VEL:   dflt_vel  = cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            notes_owed <= owed_notes.size();
        end
    end

endmodule

// ===== tb/frame_note_segmenter_top_tb.sv =====
// ----------------------------------------------------------------------------
// frame_note_segmenter_top_tb
// Drives probability frames, broken frames and flushes into the segmenter
// under several threshold settings, with random gaps and output stalls, and
// leaves prediction and comparison of the note beats to the checker.
// ----------------------------------------------------------------------------
module frame_note_segmenter_top_tb;
    import fnseg_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                    mismatches;
    int                    notes_owed;
    int                    beats_sent;
    int                    cycles;
    bit                    gaps_on;
    bit                    stalls_on;
    bit                    hold_req;
    logic [PROB_W-1:0]     cur_note_thr;
    logic [PROB_W-1:0]     cur_onset_thr;

    frame_note_segmenter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    fnseg_note_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .notes_owed (notes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("[frame_note_segmenter_top] ERROR");
        $finish;
    end

    // note receiver: random stalls, plus one long hold on request
    initial
    begin
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // bias a level towards zero, full scale and the given threshold
    function automatic logic [PROB_W-1:0] pick_level(input logic [PROB_W-1:0] thr);
        int lvl;
        int sel;
        sel = $urandom_range(0, 7);
        lvl = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (sel == 0)
            lvl = 0;
        else if (sel == 1)
            lvl = 65535;
        else if (sel > 4)
            lvl = int'($urandom_range(0, 65535));
        if (lvl < 0)
            lvl = 0;
        if (lvl > 65535)
            lvl = 65535;
        return PROB_W'(lvl);
    endfunction

    task automatic send_beat(input op_t op, input logic [PITCH_W-1:0] pitch,
                             input logic [PROB_W-1:0] prob, input logic [VEL_W-1:0] vel,
                             input logic vel_ok, input logic [PROB_W-1:0] onset,
                             input logic frame_end);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_DATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, onset, vel_ok, vel, prob, pitch};
        s_tuser  <= op;
        s_tlast  <= frame_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_junk(input op_t op, input logic frame_end);
        send_beat(op, 7'($urandom), 16'($urandom), 7'($urandom), 1'($urandom),
                  16'($urandom), frame_end);
    endtask

    // ascending pitches; repeat a probability now and then to force ties
    task automatic send_frame(input int len);
        int                pitch;
        logic [PROB_W-1:0] prob;
        pitch = $urandom_range(0, 40);
        prob  = pick_level(cur_note_thr);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) != 0)
                prob = pick_level(cur_note_thr);
            send_beat(OP_PITCH, 7'(pitch), prob, 7'($urandom), 1'($urandom),
                      (i == len - 1) ? pick_level(cur_onset_thr) : 16'($urandom),
                      i == len - 1);
            pitch += $urandom_range(1, 6);
            if (pitch > 127)
                pitch = 127;
        end
    endtask

    task automatic send_random_stream(input int n);
        int target;
        target = beats_sent + n;
        while (beats_sent < target) begin
            case ($urandom_range(0, 19))
                0: send_junk(op_t'($urandom_range(0, 1)), 1'($urandom));
                1: begin
                    // broken frame: no closing beat before the flush
                    repeat ($urandom_range(1, 4)) send_junk(OP_PITCH, 1'b0);
                    send_junk(OP_FLUSH, 1'($urandom));
                end
                2: send_junk(OP_FLUSH, 1'($urandom));
                3: send_frame($urandom_range(20, 40));
                default: send_frame($urandom_range(1, 6));
            endcase
        end
    endtask

    // hold the sender until every owed note has come out, then let it settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (notes_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [PROB_W-1:0] nthr, input logic [PROB_W-1:0] othr,
                                  input logic [VEL_W-1:0] dvel, input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOTE_THR;
        cfg_data  <= nthr;
        @(posedge clk);
        cfg_index <= CFG_ONSET_THR;
        cfg_data  <= othr;
        @(posedge clk);
        cfg_index <= CFG_DEF_VEL;
        cfg_data  <= {(CFG_W - VEL_W)'($urandom), dvel};
        @(posedge clk);
        if (poke_unused) begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_we        <= 1'b0;
        cur_note_thr  = nthr;
        cur_onset_thr = othr;
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_NOTE_THR;
        cfg_data      <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_PITCH;
        s_tlast       <= 1'b0;
        beats_sent    = 0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        hold_req      = 1'b0;
        cur_note_thr  = NOTE_THR_RESET;
        cur_onset_thr = ONSET_THR_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset thresholds
        send_beat(OP_PITCH, 7'd0, 16'd0, 7'd0, 1'b0, 16'd0, 1'b1);
        send_beat(OP_PITCH, 7'd0, 16'hFFFF, 7'd127, 1'b1, 16'd0, 1'b0);
        send_beat(OP_PITCH, 7'd127, 16'hFFFF, 7'd0, 1'b0, 16'hFFFF, 1'b1);
        send_beat(OP_PITCH, 7'd5, 16'd19661, 7'd3, 1'b1, 16'd32768, 1'b1);
        send_beat(OP_PITCH, 7'd9, 16'd19662, 7'd0, 1'b0, 16'd32769, 1'b1);
        send_beat(OP_PITCH, 7'd20, 16'd40000, 7'd64, 1'b1, 16'hFFFF, 1'b0);
        send_beat(OP_FLUSH, '1, '1, '1, 1'b1, '1, 1'b1);
        send_beat(OP_FLUSH, '0, '0, '0, 1'b0, '0, 1'b0);
        send_beat(OP_PITCH, 7'd127, 16'hFFFF, 7'd127, 1'b1, 16'hFFFF, 1'b1);
        send_beat(OP_PITCH, 7'd64, 16'd30000, 7'd1, 1'b1, 16'hFFFF, 1'b0);
        send_beat(OP_PITCH, 7'd65, 16'd30001, 7'd2, 1'b0, 16'd0, 1'b0);
        send_beat(OP_PITCH, 7'd66, 16'd30001, 7'd3, 1'b1, 16'd40000, 1'b1);
        send_beat(OP_PITCH, 7'd10, 16'd19661, 7'd5, 1'b1, 16'd40000, 1'b1);
        send_beat(OP_PITCH, 7'd11, 16'd1, 7'd6, 1'b1, 16'd0, 1'b1);
        send_beat(OP_PITCH, 7'd12, 16'd20000, 7'd7, 1'b1, 16'd0, 1'b1);
        send_beat(OP_FLUSH, '0, '0, '0, 1'b0, '0, 1'b0);
        send_random_stream(400);
        drain();

        // lowest thresholds: every non-zero level starts or closes a note
        apply_settings('0, '0, '0, 1'b0);
        send_random_stream(200);
        // keep offering beats while the receiver holds off
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        send_random_stream(60);
        gaps_on = 1'b1;
        drain();
        send_random_stream(200);
        drain();

        // highest thresholds: notes never start or close by onset
        apply_settings('1, '1, 7'h7F, 1'b0);
        send_random_stream(120);
        drain();

        apply_settings(PROB_W'($urandom_range(8000, 50000)),
                       PROB_W'($urandom_range(8000, 60000)), 7'($urandom), 1'b1);
        send_random_stream(400);
        drain();

        // final stretch with no idling on either side
        apply_settings(PROB_W'($urandom_range(8000, 50000)),
                       PROB_W'($urandom_range(8000, 60000)), 7'($urandom), 1'b0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        send_random_stream(400);
        drain();

        if (mismatches == 0)
            $display("[frame_note_segmenter_top] OK");
        else
            $display("[frame_note_segmenter_top] ERROR");
        $finish;
    end

endmodule
